/* rtl/cidat_pkg.sv */
package cidat_pkg;

  localparam int CAPACITY_DEF = 256;
  localparam int ID_W = 32;
  localparam int COUNT_W = 9;

  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_ADD    = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  typedef struct packed {
    logic vld;
    logic hit;
  } token_t;

  typedef struct packed {
    logic               found;
    logic               added;
    logic [COUNT_W-1:0] entry_count;
  } result_t;

endpackage

/* rtl/card_id_allow_table.sv */
// Channel  Direction  Handshake                  Payload
// in       input      in_valid_i / in_ready_o    operation_i, card_id_i
// out      output     out_valid_o / out_ready_i  found_o, added_o, entry_count_o
//
// A request is searched by a token stepping through one slot cell per cycle, and its result
// is registered when the token leaves the last cell; one request is searched at a time, so
// a new request is accepted only after the previous search is done.
// Reset sets the entry count to zero; the slot contents are not cleared and need no sweep.
// A finished result waits in the output register, and a second one in a skid register,
// so a new request is accepted while a result is stalled unless the skid register is full.
module card_id_allow_table import cidat_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         operation_i,
  input  logic [ID_W-1:0]    card_id_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               found_o,
  output logic               added_o,
  output logic [COUNT_W-1:0] entry_count_o
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] FullCnt = CNT_W'(CAPACITY);

  token_t tok [CAPACITY+1];

  logic             accept;
  logic             done;
  logic             busy_q, busy_d;
  logic             start_q;
  logic [1:0]       op_q;
  logic [ID_W-1:0]  id_q;
  logic [CNT_W-1:0] count_q, count_d;
  logic             wr_en;
  logic [IDX_W-1:0] wr_idx;
  result_t          res_new;
  result_t          out_q, out_d;
  result_t          skid_q, skid_d;
  logic             out_vld_q, out_vld_d;
  logic             skid_vld_q, skid_vld_d;

  assign in_ready_o = !busy_q && !skid_vld_q;
  assign accept     = in_valid_i && in_ready_o;

  assign tok[0].vld = start_q;
  assign tok[0].hit = 1'b0;

  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    cidat_cell #(
      .CNT_W (CNT_W),
      .IDX_W (IDX_W),
      .INDEX (k)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .tok_i     (tok[k]),
      .tok_o     (tok[k+1]),
      .count_i   (count_q),
      .id_i      (id_q),
      .wr_en_i   (wr_en),
      .wr_idx_i  (wr_idx),
      .wr_data_i (id_q)
    );
  end

  assign done = tok[CAPACITY].vld;

  always_comb begin
    count_d = count_q;
    wr_en   = 1'b0;
    wr_idx  = count_q[IDX_W-1:0];
    res_new.found = tok[CAPACITY].hit;
    res_new.added = 1'b0;
    if (done) begin
      unique case (op_q)
        OP_ADD: begin
          if (!tok[CAPACITY].hit) begin
            wr_en = 1'b1;
            res_new.added = 1'b1;
            // A full table wraps around to the first slot.
            if (count_q >= FullCnt) begin
              wr_idx  = '0;
              count_d = CNT_W'(1);
            end else begin
              count_d = count_q + CNT_W'(1);
            end
          end
        end
        OP_CLEAR: begin
          count_d = '0;
        end
        default: begin
        end
      endcase
    end
    res_new.entry_count = COUNT_W'(count_d);
  end

  always_comb begin
    busy_d = busy_q;
    if (accept) begin
      busy_d = 1'b1;
    end else if (done) begin
      busy_d = 1'b0;
    end
  end

  always_comb begin
    out_d      = out_q;
    out_vld_d  = out_vld_q;
    skid_d     = skid_q;
    skid_vld_d = skid_vld_q;
    if (done) begin
      if (!out_vld_q || out_ready_i) begin
        out_d     = res_new;
        out_vld_d = 1'b1;
      end else begin
        skid_d     = res_new;
        skid_vld_d = 1'b1;
      end
    end else if (out_vld_q && out_ready_i) begin
      if (skid_vld_q) begin
        out_d      = skid_q;
        skid_vld_d = 1'b0;
      end else begin
        out_vld_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q <= operation_i;
      id_q <= card_id_i;
    end
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b0;
      start_q    <= 1'b0;
      count_q    <= '0;
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      busy_q     <= busy_d;
      start_q    <= accept;
      count_q    <= count_d;
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign found_o       = out_q.found;
  assign added_o       = out_q.added;
  assign entry_count_o = out_q.entry_count;

endmodule

/* rtl/cidat_cell.sv */
module cidat_cell import cidat_pkg::*; #(
  parameter int CNT_W = 9,
  parameter int IDX_W = 8,
  parameter int INDEX = 0
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  token_t           tok_i,
  output token_t           tok_o,
  input  logic [CNT_W-1:0] count_i,
  input  logic [ID_W-1:0]  id_i,
  input  logic             wr_en_i,
  input  logic [IDX_W-1:0] wr_idx_i,
  input  logic [ID_W-1:0]  wr_data_i
);

  localparam logic [CNT_W-1:0] SlotCnt = CNT_W'(INDEX);
  localparam logic [IDX_W-1:0] SlotIdx = IDX_W'(INDEX);

  logic [ID_W-1:0] entry_q, entry_d;
  token_t          tok_q, tok_d;
  logic            live;

  // Only slots below the entry count take part in the search.
  assign live = (SlotCnt < count_i);

  always_comb begin
    tok_d.vld = tok_i.vld;
    tok_d.hit = tok_i.hit | (tok_i.vld & live & (entry_q == id_i));
  end

  always_comb begin
    entry_d = entry_q;
    if (wr_en_i && (wr_idx_i == SlotIdx)) begin
      entry_d = wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

/* tb/tb_card_id_allow_table.sv */
module tb_card_id_allow_table import cidat_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAPACITY = CAPACITY_DEF;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int RANDOM_SWIPES = 1250;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES = CAPACITY + 8;

  typedef struct {
    logic [1:0]      op;
    logic [ID_W-1:0] id;
    bit              typed;
    result_t         want;
  } swipe_row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [1:0]         operation_i;
  logic [ID_W-1:0]    card_id_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic               found_o;
  logic               added_o;
  logic [COUNT_W-1:0] entry_count_o;

  logic [ID_W-1:0] allow_ids [CAPACITY];
  int              allow_count = 0;
  int              high_water = 0;
  bit              table_wrapped = 1'b0;
  result_t         expected_results [$];
  int              error_count = 0;
  int              stall_cycles = 0;
  int              send_idle_pct = 29;
  int              recv_idle_pct = 66;
  swipe_row_t      directed_rows [20];

  card_id_allow_table #(
    .CAPACITY(CAPACITY)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .operation_i  (operation_i),
    .card_id_i    (card_id_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .found_o      (found_o),
    .added_o      (added_o),
    .entry_count_o(entry_count_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  task automatic apply_swipe(input logic [1:0] op, input logic [ID_W-1:0] id,
                             output result_t res);
    logic hit;
    hit = 1'b0;
    for (int k = 0; k < allow_count; k++) begin
      if (allow_ids[k] == id) hit = 1'b1;
    end
    res.found = hit;
    res.added = 1'b0;
    if (op == OP_ADD && !hit) begin
      if (allow_count >= CAPACITY) begin
        allow_ids[0] = id;
        allow_count = 1;
        table_wrapped = 1'b1;
      end else begin
        allow_ids[allow_count] = id;
        allow_count++;
      end
      if (allow_count > high_water) high_water = allow_count;
      res.added = 1'b1;
    end else if (op == OP_CLEAR) begin
      allow_count = 0;
      high_water = 0;
      table_wrapped = 1'b0;
    end
    res.entry_count = allow_count[COUNT_W-1:0];
  endtask

  function automatic logic [ID_W-1:0] pick_card_id(input int stored_pct);
    if (high_water > 0 && $urandom_range(0, 99) < stored_pct) begin
      return allow_ids[$urandom_range(0, high_water - 1)];
    end
    return $urandom;
  endfunction

  task automatic send_swipe(input logic [1:0] op, input logic [ID_W-1:0] id,
                            input bit typed, input result_t want);
    result_t predicted;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    operation_i <= op;
    card_id_i   <= id;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    apply_swipe(op, id, predicted);
    expected_results.push_back(typed ? want : predicted);
  endtask

  task automatic send_random_swipe();
    int          pick;
    int          clear_thr;
    logic [1:0]  op;
    logic [ID_W-1:0] id;
    result_t     unused;
    unused = '0;
    pick = $urandom_range(0, 999);
    clear_thr = table_wrapped ? 10 : 1;
    if (pick < clear_thr) begin
      op = OP_CLEAR;
      id = pick_card_id(50);
    end else if (pick < clear_thr + 30) begin
      op = OP_UNUSED;
      id = pick_card_id(50);
    end else if (pick < 400) begin
      op = OP_LOOKUP;
      id = pick_card_id(50);
    end else begin
      op = OP_ADD;
      id = pick_card_id(20);
    end
    send_swipe(op, id, 1'b0, unused);
  endtask

  task automatic check_result();
    result_t want;
    if (expected_results.size() == 0) begin
      $error("unexpected result: found=%0b added=%0b entry_count=%0d",
             found_o, added_o, entry_count_o);
      error_count++;
    end else begin
      want = expected_results.pop_front();
      if (found_o !== want.found) begin
        $error("found: expected %0b, actual %0b", want.found, found_o);
        error_count++;
      end
      if (added_o !== want.added) begin
        $error("added: expected %0b, actual %0b", want.added, added_o);
        error_count++;
      end
      if (entry_count_o !== want.entry_count) begin
        $error("entry_count: expected %0d, actual %0d", want.entry_count, entry_count_o);
        error_count++;
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) check_result();
    out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    operation_i <= OP_LOOKUP;
    card_id_i   <= '0;
    out_ready_i <= 1'b0;

    // Rows marked typed carry an expected result read straight off the behavior.
    directed_rows = '{
      '{OP_LOOKUP, 32'h0000_0000, 1'b1, '{1'b0, 1'b0, 9'd0}},
      '{OP_LOOKUP, 32'hFFFF_FFFF, 1'b1, '{1'b0, 1'b0, 9'd0}},
      '{OP_UNUSED, 32'h0000_0000, 1'b1, '{1'b0, 1'b0, 9'd0}},
      '{OP_CLEAR,  32'h0000_0000, 1'b1, '{1'b0, 1'b0, 9'd0}},
      '{OP_ADD,    32'h0000_0000, 1'b1, '{1'b0, 1'b1, 9'd1}},
      '{OP_ADD,    32'h0000_0000, 1'b1, '{1'b1, 1'b0, 9'd1}},
      '{OP_ADD,    32'hFFFF_FFFF, 1'b1, '{1'b0, 1'b1, 9'd2}},
      '{OP_LOOKUP, 32'hFFFF_FFFF, 1'b1, '{1'b1, 1'b0, 9'd2}},
      '{OP_LOOKUP, 32'h0000_0000, 1'b1, '{1'b1, 1'b0, 9'd2}},
      '{OP_UNUSED, 32'hFFFF_FFFF, 1'b1, '{1'b1, 1'b0, 9'd2}},
      '{OP_ADD,    32'h8000_0000, 1'b0, '{1'b0, 1'b0, 9'd0}},
      '{OP_ADD,    32'h0000_0001, 1'b0, '{1'b0, 1'b0, 9'd0}},
      '{OP_LOOKUP, 32'h1234_5678, 1'b0, '{1'b0, 1'b0, 9'd0}},
      '{OP_CLEAR,  32'h0000_0001, 1'b1, '{1'b1, 1'b0, 9'd0}},
      '{OP_LOOKUP, 32'h0000_0000, 1'b1, '{1'b0, 1'b0, 9'd0}},
      '{OP_ADD,    32'hA5A5_A5A5, 1'b0, '{1'b0, 1'b0, 9'd0}},
      '{OP_LOOKUP, 32'h5A5A_5A5A, 1'b0, '{1'b0, 1'b0, 9'd0}},
      '{OP_ADD,    32'h5A5A_5A5A, 1'b0, '{1'b0, 1'b0, 9'd0}},
      '{OP_ADD,    32'hA5A5_A5A5, 1'b0, '{1'b0, 1'b0, 9'd0}},
      '{OP_CLEAR,  32'hFFFF_FFFF, 1'b0, '{1'b0, 1'b0, 9'd0}}
    };

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      send_swipe(directed_rows[i].op, directed_rows[i].id, directed_rows[i].typed,
                 directed_rows[i].want);
    end

    for (int n = 0; n < RANDOM_SWIPES; n++) begin
      if (n == RANDOM_SWIPES / 3) begin
        send_idle_pct = 66;
        recv_idle_pct = 29;
      end else if (n == 2 * RANDOM_SWIPES / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      send_random_swipe();
    end
    in_valid_i <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/cidat_pkg.sv
rtl/cidat_cell.sv
rtl/card_id_allow_table.sv
tb/tb_card_id_allow_table.sv
